// ===== hdl/load_cell_weight_filter_defines.svh =====
// Assertion helpers for the load cell weight filter.
`ifndef LOAD_CELL_WEIGHT_FILTER_DEFINES_SVH
`define LOAD_CELL_WEIGHT_FILTER_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define LCWF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define LCWF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lcwf_pkg.sv =====
package lcwf_pkg;

  // Ring depth default
  localparam int unsigned WINDOW_DEFAULT = 16;

  // Field widths
  localparam int unsigned RAW_W      = 24;
  localparam int unsigned MAG_W      = RAW_W + 1;
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned MG_W       = 32;
  localparam int unsigned G_W        = 23;
  localparam int unsigned DB_W       = 20;
  localparam int unsigned Q_W        = MAG_W + GAIN_W - FRAC_W;
  localparam int unsigned SUM_W_DEFAULT = MG_W + $clog2(WINDOW_DEFAULT);

  // Port widths
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned OUT_USER_W = 2;

  // Saturation limits of the scaled sample
  localparam logic [Q_W-1:0]  SAT_NEG_MAG = Q_W'(64'h0000_0000_8000_0000);
  localparam logic [Q_W-1:0]  SAT_POS_MAG = Q_W'(64'h0000_0000_7FFF_FFFF);
  localparam logic [MG_W-1:0] MG_MIN      = 32'h8000_0000;
  localparam logic [MG_W-1:0] MG_MAX      = 32'h7FFF_FFFF;

  // Grams: (mag + 500) / 1000 as a multiply by the reciprocal, exact for 32-bit values
  localparam int unsigned     G_RECIP_W = 29;
  localparam logic [G_RECIP_W-1:0] G_RECIP = 29'd274877907;
  localparam int unsigned     G_SHIFT   = 38;
  localparam int unsigned     G_PROD_W  = MG_W + G_RECIP_W;
  localparam logic [MG_W-1:0] G_HALF    = 32'd500;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARE    = 2'd0,
    CFG_GAIN    = 2'd1,
    CFG_ZERO_DB = 2'd2,
    CFG_DISP_DB = 2'd3
  } cfg_reg_e;

  // Shared unit operations
  typedef enum logic {
    ENG_MUL = 1'b0,
    ENG_DIV = 1'b1
  } eng_op_e;

  typedef struct packed {
    logic    start;
    eng_op_e op;
  } eng_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } eng_rsp_t;

endpackage

// ===== hdl/lcwf_engine.sv =====
module lcwf_engine #(
  parameter int unsigned LoW = lcwf_pkg::SUM_W_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lcwf_pkg::eng_req_t             req_i,
  input  logic [LoW-1:0]                 opa_i,
  input  logic [lcwf_pkg::GAIN_W-1:0]    opb_i,
  output lcwf_pkg::eng_rsp_t             rsp_o,
  output logic [lcwf_pkg::GAIN_W-1:0]    hi_o,
  output logic [LoW-1:0]                 lo_o
);
  import lcwf_pkg::*;

  localparam int unsigned HiW   = GAIN_W;
  localparam int unsigned StepW = $clog2(LoW);

  logic [HiW-1:0]   hi_q, hi_d;
  logic [LoW-1:0]   lo_q, lo_d;
  logic [HiW-1:0]   b_q;
  eng_op_e          op_q;
  logic [StepW-1:0] step_q;
  logic             busy_q, done_q;

  logic [HiW:0] alu_a, alu_b, alu_sum;
  logic         alu_sub;

  // One add/subtract per step: shift-add multiply or restoring divide
  always_comb begin
    if (op_q == ENG_MUL) begin
      alu_a   = {1'b0, hi_q};
      alu_b   = lo_q[0] ? {1'b0, b_q} : '0;
      alu_sub = 1'b0;
    end else begin
      alu_a   = {1'b0, hi_q[HiW-2:0], lo_q[LoW-1]};
      alu_b   = {1'b0, b_q};
      alu_sub = 1'b1;
    end
    alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + {{HiW{1'b0}}, alu_sub};
    if (op_q == ENG_MUL) begin
      hi_d = alu_sum[HiW:1];
      lo_d = {alu_sum[0], lo_q[LoW-1:1]};
    end else begin
      // keep the partial remainder when the trial subtract borrows
      hi_d = alu_sum[HiW] ? alu_a[HiW-1:0] : alu_sum[HiW-1:0];
      lo_d = {lo_q[LoW-2:0], ~alu_sum[HiW]};
    end
  end

  // Sequence the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      op_q   <= ENG_MUL;
    end else begin
      if (req_i.start) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        op_q   <= req_i.op;
        step_q <= (req_i.op == ENG_MUL) ? StepW'(MAG_W - 1) : StepW'(LoW - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          done_q <= 1'b0;
          step_q <= step_q - StepW'(1);
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      hi_q <= '0;
      lo_q <= opa_i;
      b_q  <= opb_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign hi_o       = hi_q;
  assign lo_o       = lo_q;

endmodule

// ===== hdl/load_cell_weight_filter.sv =====
// Sample beat: gain multiply, running sum, average divide, display deadband and grams run
// in turn through MUL, SUM, DIVS, DIV, HOLD, GABS, GPROD and DONE; the next beat is taken only
// once the result is in the output register. The shared add/subtract unit does 25 steps of gain
// multiply, 32 + ceil(log2(WINDOW)) steps of average divide. A clear beat runs GABS, GPROD, DONE.
// rst_ni (async, active low) empties the filter, drops the display and restores registers.
`include "load_cell_weight_filter_defines.svh"

module load_cell_weight_filter #(
  parameter int unsigned WINDOW = lcwf_pkg::WINDOW_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lcwf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lcwf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [lcwf_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [23:0] raw_sample
  input  logic [0:0]                         s_axis_tuser,  // [0] opcode
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [31:0] displayed_mg, [54:32] displayed_g, [86:55] average_mg, [87] zero
  output logic [lcwf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic [lcwf_pkg::OUT_USER_W-1:0]    m_axis_tuser   // [0] display_valid, [1] saturated
);
  import lcwf_pkg::*;

  localparam int unsigned SumW  = MG_W + $clog2(WINDOW);
  localparam int unsigned CntW  = $clog2(WINDOW + 1);
  localparam int unsigned SlotW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned QOff  = SumW - MAG_W + FRAC_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_DIVS,
    ST_DIV,
    ST_HOLD,
    ST_GABS,
    ST_GPROD,
    ST_DONE
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [RAW_W-1:0]  tare_q;
  logic [GAIN_W-1:0] gain_q;
  logic [DB_W-1:0]   zdb_q, ddb_q;

  // Filter state
  logic [SumW-1:0]   sum_q, sum_d;
  logic [CntW-1:0]   cnt_q;
  logic [SlotW-1:0]  slot_q;
  logic [MG_W-1:0]   held_q;
  logic              held_v_q;

  // Per-item working registers
  logic              neg_q;
  logic [MG_W-1:0]   s_q;
  logic              sat_q;
  logic [MG_W-1:0]   avg_q;
  logic [MG_W-1:0]   gmag_q;
  logic              gneg_q;
  logic [G_PROD_W-1:0] gprod_q;

  // Output register
  logic              out_valid_q;
  logic [MG_W-1:0]   out_mg_q, out_avg_q;
  logic [G_W-1:0]    out_g_q;
  logic              out_dv_q, out_sat_q;

  // Sample ring
  logic [MG_W-1:0]   ring_q [WINDOW];
  logic [MG_W-1:0]   rd_q;

  // Shared unit
  eng_req_t          eng_req;
  eng_rsp_t          eng_rsp;
  logic [SumW-1:0]   eng_opa;
  logic [GAIN_W-1:0] eng_opb;
  logic [GAIN_W-1:0] eng_hi;
  logic [SumW-1:0]   eng_lo;

  logic              accept, full;
  logic [MAG_W-1:0]  d_in, mag_in;
  logic [SumW-1:0]   sum_mag;
  logic [GAIN_W+SumW-1:0] prod_w;
  logic [Q_W-1:0]    q_sc;
  logic              sat_c;
  logic [MG_W-1:0]   s_c;
  logic [MG_W-1:0]   qmag, avg_c;
  logic [MG_W:0]     hdiff, hdmag;
  logic              upd_c;
  logic [G_W-1:0]    gq, g_c;
  logic              out_free;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign full          = (cnt_q == CntW'(WINDOW));
  assign out_free      = !out_valid_q || m_axis_tready;

  // Tare subtract and magnitude of the sample
  assign d_in   = {s_axis_tdata[RAW_W-1], s_axis_tdata[RAW_W-1:0]} - {tare_q[RAW_W-1], tare_q};
  assign mag_in = d_in[MAG_W-1] ? (MAG_W'(0) - d_in) : d_in;
  assign sum_mag = sum_q[SumW-1] ? (SumW'(0) - sum_q) : sum_q;

  // Drive the shared unit
  always_comb begin
    eng_req.start = (accept && !s_axis_tuser[0]) || (state_q == ST_DIVS);
    eng_req.op    = (state_q == ST_DIVS) ? ENG_DIV : ENG_MUL;
    eng_opa       = (state_q == ST_DIVS) ? sum_mag : SumW'(mag_in);
    eng_opb       = (state_q == ST_DIVS) ? GAIN_W'(cnt_q) : gain_q;
  end

  lcwf_engine #(
    .LoW (SumW)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (eng_req),
    .opa_i  (eng_opa),
    .opb_i  (eng_opb),
    .rsp_o  (eng_rsp),
    .hi_o   (eng_hi),
    .lo_o   (eng_lo)
  );

  // Drop the fraction and clip to 32 bits
  always_comb begin
    prod_w = {eng_hi, eng_lo};
    q_sc   = prod_w[QOff +: Q_W];
    if (neg_q) begin
      sat_c = (q_sc > SAT_NEG_MAG);
      s_c   = sat_c ? MG_MIN : (MG_W'(0) - q_sc[MG_W-1:0]);
    end else begin
      sat_c = (q_sc > SAT_POS_MAG);
      s_c   = sat_c ? MG_MAX : q_sc[MG_W-1:0];
    end
  end

  // Running sum: add the new sample, retire the oldest once full
  assign sum_d = sum_q + SumW'($signed(s_q)) - (full ? SumW'($signed(rd_q)) : SumW'(0));

  // Average sign and zero deadband
  assign qmag  = eng_lo[MG_W-1:0];
  assign avg_c = (qmag <= MG_W'(zdb_q)) ? '0 :
                 (sum_q[SumW-1] ? (MG_W'(0) - qmag) : qmag);

  // Display deadband at full precision
  assign hdiff = {avg_q[MG_W-1], avg_q} - {held_q[MG_W-1], held_q};
  assign hdmag = hdiff[MG_W] ? ((MG_W+1)'(0) - hdiff) : hdiff;
  assign upd_c = !held_v_q || (hdmag >= (MG_W+1)'(ddb_q));

  // Grams from the reciprocal product
  assign gq  = gprod_q[G_SHIFT +: G_W];
  assign g_c = gneg_q ? (G_W'(0) - gq) : gq;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tare_q <= '0;
      gain_q <= GAIN_W'(32'h0001_0000);
      zdb_q  <= '0;
      ddb_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_TARE:    tare_q <= cfg_data_i[RAW_W-1:0];
        CFG_GAIN:    gain_q <= cfg_data_i[GAIN_W-1:0];
        CFG_ZERO_DB: zdb_q  <= cfg_data_i[DB_W-1:0];
        CFG_DISP_DB: ddb_q  <= cfg_data_i[DB_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, filter state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      slot_q      <= '0;
      held_q      <= '0;
      held_v_q    <= 1'b0;
      neg_q       <= 1'b0;
      s_q         <= '0;
      sat_q       <= 1'b0;
      avg_q       <= '0;
      gmag_q      <= '0;
      gneg_q      <= 1'b0;
      gprod_q     <= '0;
      out_valid_q <= 1'b0;
      out_mg_q    <= '0;
      out_g_q     <= '0;
      out_avg_q   <= '0;
      out_dv_q    <= 1'b0;
      out_sat_q   <= 1'b0;
    end else begin
      // drop the output beat once taken; the done state reloads it itself
      if (m_axis_tready && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (s_axis_tuser[0]) begin
              // clear: empty the ring and drop the display
              sum_q    <= '0;
              cnt_q    <= '0;
              slot_q   <= '0;
              held_q   <= '0;
              held_v_q <= 1'b0;
              avg_q    <= '0;
              sat_q    <= 1'b0;
              state_q  <= ST_GABS;
            end else begin
              neg_q   <= d_in[MAG_W-1];
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (eng_rsp.done) begin
            s_q     <= s_c;
            sat_q   <= sat_c;
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          sum_q   <= sum_d;
          cnt_q   <= full ? cnt_q : cnt_q + CntW'(1);
          slot_q  <= (slot_q == SlotW'(WINDOW - 1)) ? '0 : slot_q + SlotW'(1);
          state_q <= ST_DIVS;
        end
        ST_DIVS: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (eng_rsp.done) begin
            avg_q   <= avg_c;
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (upd_c) begin
            held_q   <= avg_q;
            held_v_q <= 1'b1;
          end
          state_q <= ST_GABS;
        end
        ST_GABS: begin
          gmag_q  <= (held_q[MG_W-1] ? (MG_W'(0) - held_q) : held_q) + G_HALF;
          gneg_q  <= held_q[MG_W-1];
          state_q <= ST_GPROD;
        end
        ST_GPROD: begin
          gprod_q <= G_PROD_W'(gmag_q) * G_PROD_W'(G_RECIP);
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // hold here until the output register is free
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_mg_q    <= held_q;
            out_g_q     <= g_c;
            out_avg_q   <= avg_q;
            out_dv_q    <= held_v_q;
            out_sat_q   <= sat_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Ring storage: write the new sample, read the slot it replaces
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SUM) begin
      ring_q[slot_q] <= s_q;
    end
    rd_q <= ring_q[slot_q];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_avg_q, out_g_q, out_mg_q};
  assign m_axis_tuser  = {out_sat_q, out_dv_q};

  `LCWF_ASSERT_NEXT(a_clear_empties, accept && s_axis_tuser[0], cnt_q == '0 && !held_v_q, "bad clear")
  `LCWF_ASSERT_NEXT(a_sample_mul, accept && !s_axis_tuser[0], eng_rsp.busy && state_q == ST_MUL, "no mul")
  `LCWF_ASSERT_NOW(a_done_in_wait, eng_rsp.done, state_q == ST_MUL || state_q == ST_DIV, "stray done")
  `LCWF_ASSERT_NOW(a_div_nonzero, state_q == ST_DIVS, cnt_q != '0, "divide by empty ring")

endmodule

// ===== verif/load_cell_weight_checker.sv =====
`timescale 1ns / 1ps

module load_cell_weight_checker #(
  parameter int unsigned WINDOW = lcwf_pkg::WINDOW_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [lcwf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lcwf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // sample stream
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [lcwf_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [23:0] raw_sample
  input  logic [0:0]                      s_axis_tuser,  // [0] opcode
  // weight stream
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] displayed_mg, [54:32] displayed_g, [86:55] average_mg, [87] zero
  input  logic [lcwf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic [lcwf_pkg::OUT_USER_W-1:0] m_axis_tuser,  // [0] display_valid, [1] saturated
  output int unsigned                     errors_o,
  output int unsigned                     readings_o,
  output int unsigned                     clears_o,
  output int unsigned                     clipped_o,
  output int unsigned                     held_o
);
  import lcwf_pkg::*;

  localparam logic        OPC_CLEAR = 1'b1;
  localparam int unsigned G_LSB     = MG_W;
  localparam int unsigned AVG_LSB   = MG_W + G_W;

  typedef struct {
    logic signed [MG_W-1:0] shown_mg;
    logic signed [G_W-1:0]  shown_g;
    logic signed [MG_W-1:0] avg_mg;
    logic                   shown_ok;
    logic                   clipped;
  } reading_t;

  reading_t readings_due[$];

  // register copies
  logic signed [RAW_W-1:0] tare_cnt;
  logic [GAIN_W-1:0]       gain_q16;
  logic [DB_W-1:0]         zero_band_mg;
  logic [DB_W-1:0]         show_band_mg;

  // filter copy
  logic signed [MG_W-1:0]  ring_mg [WINDOW];
  longint                  window_sum;
  int unsigned             fill;
  int unsigned             slot;
  logic signed [MG_W-1:0]  held_mg;
  logic                    held_ok;

  int unsigned errors   = 0;
  int unsigned readings = 0;
  int unsigned clears   = 0;
  int unsigned clipped  = 0;
  int unsigned held     = 0;

  assign errors_o   = errors;
  assign readings_o = readings;
  assign clears_o   = clears;
  assign clipped_o  = clipped;
  assign held_o     = held;

  task automatic empty_filter();
    foreach (ring_mg[i]) ring_mg[i] = '0;
    window_sum = 0;
    fill       = 0;
    slot       = 0;
    held_mg    = '0;
    held_ok    = 1'b0;
  endtask

  // Apply tare and gain, truncate toward zero, clip to 32 bits.
  function automatic logic signed [MG_W-1:0] scale_to_mg(
      input logic signed [RAW_W-1:0] raw, output logic clip);
    longint          net;
    longint unsigned mag;
    longint unsigned q;
    net  = longint'(raw) - longint'(tare_cnt);
    mag  = (net < 0) ? -net : net;
    q    = (mag * {32'b0, gain_q16}) >> FRAC_W;
    clip = 1'b0;
    if (net < 0) begin
      if (q > 64'h8000_0000) begin
        clip = 1'b1;
        q    = 64'h8000_0000;
      end
      return MG_W'(-longint'(q));
    end
    if (q > 64'h7FFF_FFFF) begin
      clip = 1'b1;
      q    = 64'h7FFF_FFFF;
    end
    return MG_W'(q);
  endfunction

  // Round half away from zero.
  function automatic logic signed [G_W-1:0] mg_to_grams(input logic signed [MG_W-1:0] mg);
    longint v;
    v = mg;
    if (v >= 0) return G_W'((v + 500) / 1000);
    return G_W'(-((-v + 500) / 1000));
  endfunction

  // Advance the filter copy by one beat and queue the weight it yields.
  task automatic weigh_beat(input logic op, input logic signed [RAW_W-1:0] raw);
    reading_t               r;
    logic signed [MG_W-1:0] s;
    logic                   clip;
    longint                 avg;
    longint                 drift;
    r.avg_mg  = '0;
    r.clipped = 1'b0;
    if (op == OPC_CLEAR) begin
      empty_filter();
      clears++;
    end else begin
      s = scale_to_mg(raw, clip);
      if (fill >= WINDOW) window_sum -= ring_mg[slot];
      else fill++;
      ring_mg[slot] = s;
      window_sum   += s;
      slot          = (slot + 1) % WINDOW;
      avg = window_sum / longint'(fill);
      if ((avg < 0 ? -avg : avg) <= longint'(zero_band_mg)) avg = 0;
      // deadband compare at full precision
      drift = avg - longint'(held_mg);
      if (drift < 0) drift = -drift;
      if (!held_ok || drift >= longint'(show_band_mg)) begin
        held_mg = MG_W'(avg);
        held_ok = 1'b1;
      end
      r.avg_mg  = MG_W'(avg);
      r.clipped = clip;
      if (clip) clipped++;
      if (held_mg != r.avg_mg) held++;
    end
    r.shown_mg = held_mg;
    r.shown_g  = mg_to_grams(held_mg);
    r.shown_ok = held_ok;
    readings_due.push_back(r);
  endtask

  task automatic note_miss(input string what, input longint want, input longint got);
    errors++;
    if (errors <= 10)
      $display("%0t: %s mismatch on result %0d: expected %0d, got %0d",
               $realtime, what, readings, want, got);
  endtask

  // Compare one weight beat with the oldest expectation.
  task automatic check_beat();
    reading_t want;
    if (readings_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: weight beat with nothing expected, tdata %h tuser %b",
                 $realtime, m_axis_tdata, m_axis_tuser);
      return;
    end
    want = readings_due.pop_front();
    if (m_axis_tdata[MG_W-1:0] != want.shown_mg)
      note_miss("displayed_mg", want.shown_mg, $signed(m_axis_tdata[MG_W-1:0]));
    if (m_axis_tdata[G_LSB +: G_W] != want.shown_g)
      note_miss("displayed_g", want.shown_g, $signed(m_axis_tdata[G_LSB +: G_W]));
    if (m_axis_tdata[AVG_LSB +: MG_W] != want.avg_mg)
      note_miss("average_mg", want.avg_mg, $signed(m_axis_tdata[AVG_LSB +: MG_W]));
    if (m_axis_tdata[OUT_DATA_W-1] !== 1'b0)
      note_miss("tdata pad bit", 0, m_axis_tdata[OUT_DATA_W-1]);
    if (m_axis_tuser[0] !== want.shown_ok)
      note_miss("display_valid", want.shown_ok, m_axis_tuser[0]);
    if (m_axis_tuser[1] !== want.clipped)
      note_miss("saturated", want.clipped, m_axis_tuser[1]);
    readings++;
  endtask

  // Watch all three channels at each edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tare_cnt     = '0;
      gain_q16     = 32'h0001_0000;
      zero_band_mg = '0;
      show_band_mg = '0;
      empty_filter();
      readings_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_beat();
      if (s_axis_tvalid && s_axis_tready)
        weigh_beat(s_axis_tuser[0], s_axis_tdata[RAW_W-1:0]);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_TARE:    tare_cnt     = cfg_data_i[RAW_W-1:0];
          CFG_GAIN:    gain_q16     = cfg_data_i[GAIN_W-1:0];
          CFG_ZERO_DB: zero_band_mg = cfg_data_i[DB_W-1:0];
          CFG_DISP_DB: show_band_mg = cfg_data_i[DB_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== verif/tb_load_cell_weight_filter.sv =====
`timescale 1ns / 1ps

module tb_load_cell_weight_filter;
  import lcwf_pkg::*;

  localparam int unsigned ITEMS_TOTAL  = 950;
  localparam int unsigned HOLD_CYCLES  = 900;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam longint      LIMIT_NS     = 18_000_000;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // [23:0] raw_sample
  logic [0:0]            s_axis_tuser  = '0;  // [0] opcode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [31:0] displayed_mg, [54:32] displayed_g, [86:55] average_mg, [87] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;       // [0] display_valid, [1] saturated

  int unsigned errors;
  int unsigned readings;
  int unsigned clears;
  int unsigned clipped;
  int unsigned held;

  int unsigned             beats_sent = 0;
  int unsigned             setups     = 0;
  logic signed [RAW_W-1:0] tare_now   = '0;
  logic                    src_pace   = 1'b0;
  logic                    sink_pace  = 1'b0;
  logic                    hold_req   = 1'b0;

  always #6 clk_i = ~clk_i;

  load_cell_weight_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  load_cell_weight_checker weigh_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .errors_o      (errors),
    .readings_o    (readings),
    .clears_o      (clears),
    .clipped_o     (clipped),
    .held_o        (held)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 150);
    return $urandom_range(1, 4);
  endfunction

  function automatic logic [DB_W-1:0] pick_band();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return DB_W'($urandom());
      default: return DB_W'($urandom_range(0, 3000));
    endcase
  endfunction

  // Offer one beat and hold it until taken.
  task automatic offer_beat(input logic clear_req, input logic [RAW_W-1:0] raw);
    if (src_pace && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle_len()) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    s_axis_tuser  <= clear_req;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  // Stop offering and wait for every weight beat still owed.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (readings != beats_sent);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Write all four registers once the filter is idle; unused upper bits get noise.
  task automatic setup(input logic [RAW_W-1:0] tare, input logic [GAIN_W-1:0] gain,
                       input logic [DB_W-1:0] zero_db, input logic [DB_W-1:0] show_db);
    drain();
    write_reg(CFG_TARE,    {8'($urandom()), tare});
    write_reg(CFG_GAIN,    gain);
    write_reg(CFG_ZERO_DB, {12'($urandom()), zero_db});
    write_reg(CFG_DISP_DB, {12'($urandom()), show_db});
    cfg_valid_i <= 1'b0;
    tare_now = tare;
    setups++;
  endtask

  // Pace the weight side; a hold-off request stalls it for a counted stretch.
  initial begin : weight_pacing
    int unsigned gap;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (sink_pace && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        gap = idle_len();
        repeat (gap) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int unsigned          n;
    int unsigned          r;
    int                   load;
    int                   spread;
    int                   noise;
    logic [RAW_W-1:0]     tare;
    logic [GAIN_W-1:0]    gain;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: no tare, unity gain, no deadbands
    offer_beat(1'b0, 24'h7FFFFF);
    offer_beat(1'b0, 24'h800000);
    offer_beat(1'b0, 24'h000000);
    offer_beat(1'b0, 24'hFFFFFF);
    offer_beat(1'b0, 24'h000001);
    offer_beat(1'b1, 24'hFFFFFF);
    offer_beat(1'b0, -24'sd1234);

    // clip high, then low, at full gain and extreme tare
    setup(24'h800000, 32'hFFFF_FFFF, '0, '0);
    offer_beat(1'b0, 24'h7FFFFF);
    offer_beat(1'b1, '0);
    setup(24'h7FFFFF, 32'hFFFF_FFFF, '0, '0);
    offer_beat(1'b0, 24'h800000);
    offer_beat(1'b1, '0);

    // exactly -2^31 passes, +2^31 clips
    setup(24'h000000, 32'h0100_0000, '0, '0);
    offer_beat(1'b0, 24'h800000);
    offer_beat(1'b0, 24'h7FFFFF);
    setup(24'hFFFFFF, 32'h0100_0000, '0, '0);
    offer_beat(1'b0, 24'h7FFFFF);
    offer_beat(1'b1, '0);

    // zero gain
    setup('0, '0, '0, '0);
    offer_beat(1'b0, RAW_W'($urandom()));

    // both deadbands at their widest
    setup('0, 32'h0001_0000, '1, '1);
    offer_beat(1'b0, 24'd1000);
    offer_beat(1'b0, 24'h7FFFFF);
    offer_beat(1'b0, 24'h800000);
    offer_beat(1'b1, '0);

    // display holds inside a 1000 mg band
    setup('0, 32'h0001_0000, '0, 20'd1000);
    offer_beat(1'b0, 24'd5000);
    offer_beat(1'b0, 24'd5999);
    offer_beat(1'b0, 24'd7500);
    offer_beat(1'b1, '0);

    // half-gram rounding both signs
    setup('0, 32'h0001_0000, '0, '0);
    offer_beat(1'b0, 24'd1500);
    offer_beat(1'b0, -24'sd4500);

    // random phases: a steady load with noise, some outliers and clears
    for (int phase = 0; beats_sent < ITEMS_TOTAL; phase++) begin
      case ($urandom_range(0, 5))
        0:       tare = 24'h800000;
        1:       tare = 24'h7FFFFF;
        2:       tare = RAW_W'($urandom());
        default: tare = RAW_W'($urandom_range(0, 20000) - 10000);
      endcase
      case ($urandom_range(0, 5))
        0:       gain = '0;
        1:       gain = '1;
        2:       gain = $urandom();
        default: gain = $urandom_range(20000, 300000);
      endcase
      setup(tare, gain, pick_band(), pick_band());
      src_pace  = (phase % 4) != 0;
      sink_pace = (phase % 3) != 1;
      // fill the block while the weight side is held off
      if (phase == 1 || phase == 6) begin
        src_pace = 1'b0;
        hold_req = 1'b1;
      end
      case ($urandom_range(0, 3))
        0:       spread = 0;
        1:       spread = 2;
        2:       spread = 40;
        default: spread = 1500;
      endcase
      load = $urandom_range(0, 2000) - 1000;
      n    = $urandom_range(50, 90);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          offer_beat(1'b1, RAW_W'($urandom()));
        end else if (r < 16) begin
          offer_beat(1'b0, RAW_W'($urandom()));
        end else begin
          // step the load now and then
          if (r < 20) begin
            case ($urandom_range(0, 2))
              0:       load = $urandom_range(0, 2000) - 1000;
              1:       load = $urandom_range(0, 200000) - 100000;
              default: load = $urandom_range(0, 16000000) - 8000000;
            endcase
          end
          noise = $urandom_range(0, 2 * spread) - spread;
          offer_beat(1'b0, RAW_W'(tare_now + load + noise));
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("tb: %0d beats, %0d weights checked over %0d register setups",
             beats_sent, readings, setups);
    $display("tb: %0d clears, %0d clipped samples, %0d displays held by deadband",
             clears, clipped, held);
    if (errors == 0 && readings == beats_sent) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #LIMIT_NS;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/lcwf_pkg.sv
hdl/lcwf_engine.sv
hdl/load_cell_weight_filter.sv
verif/load_cell_weight_checker.sv
verif/tb_load_cell_weight_filter.sv
